FILE: src/trn_pkg.sv
package trn_pkg;

  // action codes
  localparam logic [1:0] ACT_TOKEN  = 2'd0;
  localparam logic [1:0] ACT_SUBMIT = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // token types
  localparam logic [2:0] TOK_JOIN     = 3'd0;
  localparam logic [2:0] TOK_JOIN_ACK = 3'd1;
  localparam logic [2:0] TOK_FREE     = 3'd2;
  localparam logic [2:0] TOK_FULL     = 3'd3;
  localparam logic [2:0] TOK_RETURN   = 3'd4;

  // result events
  localparam logic [2:0] EV_SEND      = 3'd0;
  localparam logic [2:0] EV_FOR_ME    = 3'd1;
  localparam logic [2:0] EV_DROPPED   = 3'd2;
  localparam logic [2:0] EV_CONFIRMED = 3'd3;
  localparam logic [2:0] EV_BUSY      = 3'd4;

  // config register map
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_ID           = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LISTEN_PORT       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_NEXT_ADDR   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_NEXT_PORT   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STARTS_WITH_TOKEN = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TTL_START         = 3'd5;

  // reset values
  localparam logic [31:0] RST_NODE_ID           = 32'd1;
  localparam logic [15:0] RST_LISTEN_PORT       = 16'd1024;
  localparam logic [31:0] RST_FIRST_NEXT_ADDR   = 32'd0;
  localparam logic [15:0] RST_FIRST_NEXT_PORT   = 16'd1024;
  localparam logic        RST_STARTS_WITH_TOKEN = 1'b0;
  localparam logic [7:0]  RST_TTL_START         = 8'd3;

  // one result beat, payload carried alongside
  typedef struct packed {
    logic [2:0]  ev;
    logic [2:0]  typ;
    logic [31:0] dest;
    logic [31:0] source;
    logic [31:0] join_addr;
    logic [15:0] jport;
    logic [31:0] count;
    logic [7:0]  ttl;
    logic [31:0] send_addr;
    logic [15:0] send_port;
  } rec_t;

  // work handed from front to back: one or two beats
  typedef struct packed {
    logic two;
    rec_t r0;
    rec_t r1;
  } job_t;

endpackage

FILE: src/trn_ifs.sv
interface trn_in_if #(parameter int PAYLOAD_BITS = 64);
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [2:0]              tok_type;
  logic [31:0]             tok_dest;
  logic [31:0]             tok_source;
  logic [PAYLOAD_BITS-1:0] tok_payload;
  logic [31:0]             tok_join_addr;
  logic [15:0]             tok_join_port;
  logic [31:0]             tok_count;
  logic [7:0]              tok_ttl;
  logic [31:0]             peer_addr;

  modport source (
    output valid, action, tok_type, tok_dest, tok_source, tok_payload,
           tok_join_addr, tok_join_port, tok_count, tok_ttl, peer_addr,
    input  ready
  );
  modport sink (
    input  valid, action, tok_type, tok_dest, tok_source, tok_payload,
           tok_join_addr, tok_join_port, tok_count, tok_ttl, peer_addr,
    output ready
  );
endinterface

interface trn_out_if #(parameter int PAYLOAD_BITS = 64);
  logic                    valid;
  logic                    ready;
  logic [2:0]              event_res;
  logic [2:0]              out_type;
  logic [31:0]             out_dest;
  logic [31:0]             out_source;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [31:0]             out_join_addr;
  logic [15:0]             out_join_port;
  logic [31:0]             out_count;
  logic [7:0]              out_ttl;
  logic [31:0]             send_addr;
  logic [15:0]             send_port;
  logic                    last;

  modport source (
    output valid, event_res, out_type, out_dest, out_source, out_payload,
           out_join_addr, out_join_port, out_count, out_ttl, send_addr,
           send_port, last,
    input  ready
  );
  modport sink (
    input  valid, event_res, out_type, out_dest, out_source, out_payload,
           out_join_addr, out_join_port, out_count, out_ttl, send_addr,
           send_port, last,
    output ready
  );
endinterface

FILE: src/trn_front.sv
module trn_front import trn_pkg::*; #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  trn_in_if.sink                    in_ch,
  input  logic                      q_full,
  output logic                      push,
  output job_t                      job,
  output logic [PAYLOAD_BITS-1:0]   pay0,
  output logic [PAYLOAD_BITS-1:0]   pay1
);

  logic [31:0] node_id_r;
  logic [15:0] listen_port_r;
  logic [31:0] first_next_addr_r;
  logic [15:0] first_next_port_r;
  logic        starts_tok_r;
  logic [7:0]  ttl_start_r;

  logic [31:0]             next_addr_r, next_addr_nxt;
  logic [15:0]             next_port_r, next_port_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [31:0]             pend_dest_r, pend_dest_nxt;
  logic [PAYLOAD_BITS-1:0] pend_pay_r, pend_pay_nxt;

  logic                    acc;
  logic [1:0]              nres;
  rec_t                    base, snd, rep;
  logic [PAYLOAD_BITS-1:0] snd_pay;
  logic [31:0]             cnt_inc;
  logic [7:0]              ttl_dec, ttl_new;
  logic                    dest_here, src_here, drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r         <= RST_NODE_ID;
      listen_port_r     <= RST_LISTEN_PORT;
      first_next_addr_r <= RST_FIRST_NEXT_ADDR;
      first_next_port_r <= RST_FIRST_NEXT_PORT;
      starts_tok_r      <= RST_STARTS_WITH_TOKEN;
      ttl_start_r       <= RST_TTL_START;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID:           node_id_r         <= cfg_data[31:0];
        CFG_LISTEN_PORT:       listen_port_r     <= cfg_data[15:0];
        CFG_FIRST_NEXT_ADDR:   first_next_addr_r <= cfg_data[31:0];
        CFG_FIRST_NEXT_PORT:   first_next_port_r <= cfg_data[15:0];
        CFG_STARTS_WITH_TOKEN: starts_tok_r      <= cfg_data[0];
        CFG_TTL_START:         ttl_start_r       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_addr_r  <= RST_FIRST_NEXT_ADDR;
      next_port_r  <= RST_FIRST_NEXT_PORT;
      pend_valid_r <= 1'b0;
    end else if (acc) begin
      next_addr_r  <= next_addr_nxt;
      next_port_r  <= next_port_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // pending message words are only read while pending is set
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_dest_r <= pend_dest_nxt;
      pend_pay_r  <= pend_pay_nxt;
    end
  end

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign cnt_inc     = in_ch.tok_count + 32'd1;
  assign ttl_dec     = (in_ch.tok_ttl != 8'd0) ? in_ch.tok_ttl - 8'd1 : 8'd0;
  assign dest_here   = (in_ch.tok_dest == node_id_r);
  assign src_here    = (in_ch.tok_source == node_id_r);
  assign ttl_new     = src_here ? ttl_dec : in_ch.tok_ttl;
  assign drop        = src_here && (ttl_new == 8'd0);

  // arriving token as a send beat to the current next hop
  always_comb begin
    base           = '0;
    base.ev        = EV_SEND;
    base.typ       = in_ch.tok_type;
    base.dest      = in_ch.tok_dest;
    base.source    = in_ch.tok_source;
    base.join_addr = in_ch.tok_join_addr;
    base.jport     = in_ch.tok_join_port;
    base.count     = in_ch.tok_count;
    base.ttl       = in_ch.tok_ttl;
    base.send_addr = next_addr_r;
    base.send_port = next_port_r;
  end

  always_comb begin
    next_addr_nxt  = next_addr_r;
    next_port_nxt  = next_port_r;
    pend_valid_nxt = pend_valid_r;
    pend_dest_nxt  = pend_dest_r;
    pend_pay_nxt   = pend_pay_r;
    nres           = 2'd0;
    snd            = base;
    snd_pay        = in_ch.tok_payload;
    rep            = '0;
    job            = '0;
    pay0           = '0;
    pay1           = '0;

    case (in_ch.action)
      ACT_START: begin
        next_addr_nxt      = first_next_addr_r;
        next_port_nxt      = first_next_port_r;
        job.r0.ev          = EV_SEND;
        job.r0.typ         = TOK_JOIN;
        job.r0.jport       = listen_port_r;
        job.r0.send_addr   = first_next_addr_r;
        job.r0.send_port   = first_next_port_r;
        job.r1.ev          = EV_SEND;
        job.r1.typ         = TOK_FREE;
        job.r1.send_addr   = first_next_addr_r;
        job.r1.send_port   = first_next_port_r;
        nres               = starts_tok_r ? 2'd2 : 2'd1;
      end
      ACT_SUBMIT: begin
        if (pend_valid_r) begin
          job.r0.ev   = EV_BUSY;
          job.r0.dest = in_ch.tok_dest;
          pay0        = in_ch.tok_payload;
          nres        = 2'd1;
        end else begin
          pend_valid_nxt = 1'b1;
          pend_dest_nxt  = in_ch.tok_dest;
          pend_pay_nxt   = in_ch.tok_payload;
        end
      end
      ACT_TOKEN: begin
        case (in_ch.tok_type)
          TOK_JOIN: begin
            // splice joiner in behind us; it gets our old next hop
            snd.typ       = TOK_JOIN_ACK;
            snd.join_addr = next_addr_r;
            snd.jport     = next_port_r;
            snd.send_addr = in_ch.peer_addr;
            snd.send_port = in_ch.tok_join_port;
            next_addr_nxt = in_ch.peer_addr;
            next_port_nxt = in_ch.tok_join_port;
            job.r0        = snd;
            pay0          = snd_pay;
            nres          = 2'd1;
          end
          TOK_JOIN_ACK: begin
            next_addr_nxt = in_ch.tok_join_addr;
            next_port_nxt = in_ch.tok_join_port;
          end
          TOK_FREE: begin
            if (pend_valid_r) begin
              pend_valid_nxt = 1'b0;
              pend_dest_nxt  = '0;
              pend_pay_nxt   = '0;
              snd.typ        = TOK_FULL;
              snd.dest       = pend_dest_r;
              snd.source     = node_id_r;
              snd.ttl        = ttl_start_r;
              snd_pay        = pend_pay_r;
            end
            snd.count = cnt_inc;
            job.r0    = snd;
            pay0      = snd_pay;
            nres      = 2'd1;
          end
          TOK_FULL: begin
            snd.count = cnt_inc;
            snd.ttl   = ttl_new;
            if (dest_here) begin
              snd.typ  = TOK_RETURN;
              snd.dest = '0;
              snd_pay  = '0;
            end
            if (drop) begin
              snd.typ    = TOK_FREE;
              snd.dest   = '0;
              snd.source = '0;
              snd_pay    = '0;
            end
            // delivery report wins over the drop report
            rep.ev     = dest_here ? EV_FOR_ME : EV_DROPPED;
            rep.dest   = in_ch.tok_dest;
            rep.source = in_ch.tok_source;
            if (dest_here || drop) begin
              job.r0 = rep;
              pay0   = in_ch.tok_payload;
              job.r1 = snd;
              pay1   = snd_pay;
              nres   = 2'd2;
            end else begin
              job.r0 = snd;
              pay0   = snd_pay;
              nres   = 2'd1;
            end
          end
          TOK_RETURN: begin
            if (src_here) begin
              rep.ev     = EV_CONFIRMED;
              rep.dest   = in_ch.tok_dest;
              rep.source = in_ch.tok_source;
              snd.typ    = TOK_FREE;
              snd.source = '0;
              snd.count  = cnt_inc;
              job.r0     = rep;
              job.r1     = snd;
              pay1       = snd_pay;
              nres       = 2'd2;
            end else begin
              job.r0 = snd;
              pay0   = snd_pay;
              nres   = 2'd1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    job.two = (nres == 2'd2);
    push    = acc && (nres != 2'd0);
  end

endmodule

FILE: src/trn_queue.sv
module trn_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'(DEPTH));
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

FILE: src/trn_back.sv
module trn_back import trn_pkg::*; #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  job_t                    q_job,
  input  logic [PAYLOAD_BITS-1:0] q_pay0,
  input  logic [PAYLOAD_BITS-1:0] q_pay1,
  output logic                    q_pop,
  trn_out_if.source               out_ch
);

  logic                    out_valid_r;
  rec_t                    out_rec_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic                    out_last_r;
  logic                    sel_r;

  logic load, take, beat_last;

  assign load      = !out_valid_r || out_ch.ready;
  assign take      = load && !q_empty;
  assign beat_last = sel_r || !q_job.two;
  assign q_pop     = take && beat_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (take) sel_r <= !beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_rec_r  <= sel_r ? q_job.r1 : q_job.r0;
      out_pay_r  <= sel_r ? q_pay1 : q_pay0;
      out_last_r <= beat_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = out_rec_r.ev;
  assign out_ch.out_type      = out_rec_r.typ;
  assign out_ch.out_dest      = out_rec_r.dest;
  assign out_ch.out_source    = out_rec_r.source;
  assign out_ch.out_payload   = out_pay_r;
  assign out_ch.out_join_addr = out_rec_r.join_addr;
  assign out_ch.out_join_port = out_rec_r.jport;
  assign out_ch.out_count     = out_rec_r.count;
  assign out_ch.out_ttl       = out_rec_r.ttl;
  assign out_ch.send_addr     = out_rec_r.send_addr;
  assign out_ch.send_port     = out_rec_r.send_port;
  assign out_ch.last          = out_last_r;

endmodule

FILE: src/token_ring_node_step.sv
// One node of a token ring. Each input beat is an arriving token, a user's
// send request or a start command; the node answers with zero, one or two
// result beats (last marks the final one). The front stage takes an input
// beat, updates the next-hop and pending-message state and builds every
// result of that beat at once; a two-entry queue hands the work to the back
// stage, which plays the results out through an output register, one beat
// per cycle while out_ch is ready. With the output side always ready the
// node takes a new input every cycle while results keep up: an item costs
// one output beat per result, so a stream of two-result items is limited
// by the single output register. Results pass through the queue and the
// output register. Configuration writes land at once and are meant for an
// idle node; next hop only picks up first_next_addr/port on a start command.
module token_ring_node_step import trn_pkg::*; #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  trn_in_if.sink                    in_ch,
  trn_out_if.source                 out_ch
);

  // queue word: job header then both payload words
  localparam int QW = $bits(job_t) + 2 * PAYLOAD_BITS;

  logic                    push, pop, q_full, q_empty;
  job_t                    f_job, q_job;
  logic [PAYLOAD_BITS-1:0] f_pay0, f_pay1, q_pay0, q_pay1;
  logic [QW-1:0]           q_wdata, q_rdata;

  // front: classify the beat, update ring state, build results
  trn_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .job       (f_job),
    .pay0      (f_pay0),
    .pay1      (f_pay1)
  );

  assign q_wdata = {f_job, f_pay0, f_pay1};

  // decouples input acceptance from output backpressure
  trn_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {q_job, q_pay0, q_pay1} = q_rdata;

  // back: serialize one or two beats per job
  trn_back #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (q_job),
    .q_pay0  (q_pay0),
    .q_pay1  (q_pay1),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
